### sv/rdsr_pkg.sv
// Shared types, constants and tables for the reaction-diffusion rate block.
// Used by the divider, datapath, controller and top level; depends on nothing.
`default_nettype none

package rdsr_pkg;

    // Grid geometry
    localparam int MAX_COLS = 256;
    localparam int MAX_ROWS = 256;
    localparam int IDX_W    = $clog2(MAX_COLS);
    localparam int DIM_W    = 9;
    localparam int ADDR_W   = IDX_W + 1;
    localparam logic [DIM_W-1:0] DIM_MIN   = DIM_W'(2);
    localparam logic [DIM_W-1:0] COLS_LIM  = DIM_W'(MAX_COLS);
    localparam logic [DIM_W-1:0] ROWS_LIM  = DIM_W'(MAX_ROWS);

    // Register indexes
    localparam logic [2:0] CFG_COEF_X  = 3'd0;
    localparam logic [2:0] CFG_COEF_Y  = 3'd1;
    localparam logic [2:0] CFG_GAIN    = 3'd2;
    localparam logic [2:0] CFG_OPA     = 3'd3;
    localparam logic [2:0] CFG_COLS    = 3'd4;
    localparam logic [2:0] CFG_ROWS    = 3'd5;

    // Register reset values
    localparam logic [31:0] COEF_RST = 32'd10342656;
    localparam logic [31:0] GAIN_RST = 32'd4194304;
    localparam logic [31:0] OPA_RST  = 32'd33554432;
    localparam logic [DIM_W-1:0] DIM_RST = DIM_W'(201);

    // Arithmetic constants
    localparam logic [31:0] LOG2E_Q30 = 32'd1549082005;
    localparam logic [31:0] LN2_Q30   = 32'd744261118;
    localparam logic [31:0] RECIP3    = 32'hAAAA_AAAB;
    localparam logic [31:0] ONE30     = 32'h4000_0000;
    localparam int          QUOT_W    = 49;

    // Datapath operations, in program order
    typedef enum logic [3:0] {
        OP_LAP = 4'd0,
        OP_MX  = 4'd1,
        OP_MY  = 4'd2,
        OP_DIV = 4'd3,
        OP_B   = 4'd4,
        OP_U   = 4'd5,
        OP_H0  = 4'd6,
        OP_UH1 = 4'd7,
        OP_D3  = 4'd8,
        OP_UH2 = 4'd9,
        OP_UH3 = 4'd10,
        OP_G   = 4'd11,
        OP_X   = 4'd12,
        OP_R   = 4'd13
    } op_t;

    // Result kinds: row above, last row left neighbor, last row corner
    typedef enum logic [1:0] {
        JOB_A = 2'd0,
        JOB_B = 2'd1,
        JOB_C = 2'd2
    } job_t;

    typedef enum logic [1:0] {
        SLOT_Y     = 2'd0,
        SLOT_LEFT  = 2'd1,
        SLOT_RIGHT = 2'd2,
        SLOT_UP    = 2'd3
    } slot_t;

    typedef struct packed {
        logic  accept;
        logic  start;
        op_t   op;
        logic  rd_en;
        slot_t slot;
        job_t  job;
        logic  emit;
        logic  last;
        logic  store;
    } cmd_t;

    typedef struct packed {
        logic [2:0] jobs;
        logic       dom;
        logic       a_small;
        logic       mul_done;
        logic       div_done;
        logic       out_free;
    } sts_t;

    // 2^(k/8) in Q2.30
    function automatic logic [31:0] pow2_frac(input logic [2:0] k);
        logic [31:0] v;
        unique case (k)
            3'd0: v = 32'd1073741824;
            3'd1: v = 32'd1170923762;
            3'd2: v = 32'd1276901417;
            3'd3: v = 32'd1392470869;
            3'd4: v = 32'd1518500250;
            3'd5: v = 32'd1655936265;
            3'd6: v = 32'd1805811301;
            3'd7: v = 32'd1969251188;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

### sv/reaction_diffusion_stencil_rate_unit.sv
// Top level of the five-point reaction-diffusion rate unit.
// Depends on rdsr_pkg, rdsr_ctrl and rdsr_dp.
//
// Grid samples (signed Q8.24) enter in raster order, one word per handshake, and
// each produces zero to three rate words (signed Q24.24, saturated) for cells one
// row behind, with the final row flushed as its samples arrive; "last" marks the
// final word of a sample. One sample is handled at a time: each word is formed by
// the 49-step reciprocal divider and eleven passes through the shared multiplier;
// a word for a cell at or below zero skips the reaction part. Configuration writes
// are taken every cycle and belong between samples; writing cols or rows restarts
// the frame.
`default_nettype none

module reaction_diffusion_stencil_rate_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [31:0] sample,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       col,
    output logic [7:0]       row,
    output logic [47:0]      rate,
    output logic             domain_error,
    output logic             last,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    import rdsr_pkg::*;

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    rdsr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .sts      (sts)
    );

    rdsr_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .sample       (sample),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .col          (col),
        .row          (row),
        .rate         (rate),
        .domain_error (domain_error),
        .last         (last)
    );

endmodule

`default_nettype wire

### sv/rdsr_div.sv
// Restoring divider forming floor(2^48 / d), one quotient bit per cycle.
// Depends on rdsr_pkg.
`default_nettype none

module rdsr_div (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [30:0]                   divisor,
    output logic      [rdsr_pkg::QUOT_W-1:0]   quot,
    output logic                               done
);
    import rdsr_pkg::*;

    localparam int CNT_W = $clog2(QUOT_W);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [30:0]       rem_reg;
    logic [30:0]       dvs_reg;
    logic [QUOT_W-1:0] quot_reg;

    logic [31:0]       trial;
    logic              fits;
    logic [31:0]       diff;

    // Shift in the next dividend bit; only the top bit of 2^48 is set
    always_comb
    begin
        trial = {rem_reg, (cnt_reg == '0)};
        fits  = trial >= {1'b0, dvs_reg};
        diff  = trial - {1'b0, dvs_reg};
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == CNT_W'(QUOT_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    // Remainder and quotient
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg  <= fits ? diff[30:0] : trial[30:0];
            quot_reg <= {quot_reg[QUOT_W-2:0], fits};
        end
    end

    assign quot = quot_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

### sv/rdsr_dp.sv
// Datapath: registers, line store, shared multiplier, divider and result register.
// Depends on rdsr_pkg and rdsr_div; driven by rdsr_ctrl through cmd_t/sts_t.
`default_nettype none

module rdsr_dp (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire rdsr_pkg::cmd_t      cmd,
    output rdsr_pkg::sts_t           sts,
    input  wire logic [31:0]         sample,
    input  wire logic                cfg_valid,
    input  wire logic [2:0]          cfg_index,
    input  wire logic [31:0]         cfg_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [7:0]               col,
    output logic [7:0]               row,
    output logic [47:0]              rate,
    output logic                     domain_error,
    output logic                     last
);
    import rdsr_pkg::*;

    // Configuration
    logic [31:0]      coef_x_reg, coef_y_reg, gain_reg, opa_reg;
    logic [DIM_W-1:0] cols_reg, rows_reg;
    logic [DIM_W-1:0] nc, nr;

    // Position
    logic [IDX_W-1:0] colc_reg, rowc_reg, i_reg, j_reg;
    logic signed [31:0] s_reg;

    // Line store
    logic [31:0]       mem [2*MAX_COLS];
    logic [31:0]       rdata_reg;
    logic              rvalid_reg;
    slot_t             rslot_reg;
    logic [IDX_W-1:0]  rd_col;
    logic              rd_par;

    // Operands and intermediates
    logic signed [31:0] y_reg, left_reg, right_reg, up_reg;
    logic signed [34:0] lx_reg, ly_reg;
    logic               dom_reg;
    logic signed [63:0] acc_reg;
    logic signed [49:0] a_reg;
    logic [31:0]        b_reg, u_reg, t_reg, h_reg, e_reg;
    logic signed [47:0] x_reg;

    // Multiplier
    logic signed [47:0] ma_reg, ma_c;
    logic [31:0]        mb_reg, mb_c;
    logic [5:0]         msh_reg, msh_c;
    op_t                mop_reg;
    logic               mv1_reg, mv2_reg, mv3_reg;
    logic signed [64:0] plo_reg, phi_reg;
    logic signed [80:0] msum;
    logic signed [80:0] mshift;
    logic signed [63:0] mres_reg;
    logic               mul_op;

    // Divider
    logic [QUOT_W-1:0]  quot;
    logic               div_done;

    // Misc combinational
    logic [IDX_W-1:0]   jc, jr;
    logic               last_row;
    logic signed [31:0] yv, rv;
    logic signed [34:0] y35, l35, r35, u35, d35, lx_c, ly_c;
    logic [31:0]        g;
    logic [7:0]         n8, m8;
    logic [31:0]        e_c;
    logic [47:0]        rate_c;
    logic [DIM_W-1:0]   ni, nj;

    logic               out_valid_reg;
    logic [7:0]         col_reg, row_reg;
    logic [47:0]        rate_reg;
    logic               dom_out_reg, last_reg;

    // Clamp geometry
    always_comb
    begin
        priority if (cols_reg < DIM_MIN) nc = DIM_MIN;
        else if (cols_reg > COLS_LIM)    nc = COLS_LIM;
        else                             nc = cols_reg;
        priority if (rows_reg < DIM_MIN) nr = DIM_MIN;
        else if (rows_reg > ROWS_LIM)    nr = ROWS_LIM;
        else                             nr = rows_reg;
    end

    // Jobs caused by the current position
    always_comb
    begin
        last_row = {1'b0, j_reg} == (nr - 1'b1);
        sts.jobs[0] = j_reg != '0;
        sts.jobs[1] = last_row && (i_reg != '0);
        sts.jobs[2] = last_row && ({1'b0, i_reg} == (nc - 1'b1));
    end

    // Cell of the current job
    always_comb
    begin
        jc = i_reg;
        jr = j_reg;
        case (cmd.job)
            JOB_A:   jr = j_reg - 1'b1;
            JOB_B:   jc = i_reg - 1'b1;
            default: ;
        endcase
    end

    // Line store read address per job and slot
    always_comb
    begin
        rd_col = i_reg;
        rd_par = j_reg[0];
        case (cmd.job)
            JOB_A:
            begin
                rd_par = ~j_reg[0];
                unique case (cmd.slot)
                    SLOT_Y:     rd_col = i_reg;
                    SLOT_LEFT:  rd_col = i_reg - 1'b1;
                    SLOT_RIGHT: rd_col = i_reg + 1'b1;
                    SLOT_UP:    rd_par = j_reg[0];
                endcase
            end
            JOB_B:
            begin
                unique case (cmd.slot)
                    SLOT_Y:     rd_col = i_reg - 1'b1;
                    SLOT_LEFT:  rd_col = i_reg - 2'd2;
                    SLOT_RIGHT: rd_col = i_reg;
                    SLOT_UP:
                    begin
                        rd_col = i_reg - 1'b1;
                        rd_par = ~j_reg[0];
                    end
                endcase
            end
            default:
            begin
                unique case (cmd.slot)
                    SLOT_LEFT:  rd_col = i_reg - 1'b1;
                    SLOT_UP:    rd_par = ~j_reg[0];
                    default:    rd_col = i_reg;
                endcase
            end
        endcase
    end

    // Line store: one write or one read per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.store)
            mem[{j_reg[0], i_reg}] <= s_reg;
        if (cmd.rd_en)
            rdata_reg <= mem[{rd_par, rd_col}];
    end

    // Second differences, with the current sample substituted where it is a neighbor
    always_comb
    begin
        yv  = (cmd.job == JOB_C) ? s_reg : y_reg;
        rv  = (cmd.job == JOB_B) ? s_reg : right_reg;
        y35 = 35'(yv);
        l35 = 35'(left_reg);
        r35 = 35'(rv);
        u35 = 35'(up_reg);
        d35 = 35'(s_reg);
        priority if (jc == '0)
            lx_c = (r35 <<< 1) - (y35 <<< 1);
        else if ({1'b0, jc} == (nc - 1'b1))
            lx_c = l35 - (y35 <<< 1) + 35'sd16777216;
        else
            lx_c = l35 - (y35 <<< 1) + r35;
        priority if (jr == '0)
            ly_c = (d35 <<< 1) - (y35 <<< 1);
        else if ({1'b0, jr} == (nr - 1'b1))
            ly_c = u35 - (y35 <<< 1) + 35'sd16777216;
        else
            ly_c = u35 - (y35 <<< 1) + d35;
    end

    // Multiplier operand select
    always_comb
    begin
        mul_op = 1'b1;
        ma_c   = '0;
        mb_c   = '0;
        msh_c  = 6'd30;
        unique case (cmd.op)
            OP_MX:
            begin
                ma_c  = 48'(lx_reg);
                mb_c  = coef_x_reg;
                msh_c = 6'd8;
            end
            OP_MY:
            begin
                ma_c  = 48'(ly_reg);
                mb_c  = coef_y_reg;
                msh_c = 6'd8;
            end
            OP_B:
            begin
                ma_c = a_reg[47:0];
                mb_c = LOG2E_Q30;
            end
            OP_U:
            begin
                ma_c  = $signed({27'd0, b_reg[20:0]});
                mb_c  = LN2_Q30;
                msh_c = 6'd24;
            end
            OP_UH1, OP_UH2, OP_UH3:
            begin
                ma_c = $signed({16'd0, u_reg});
                mb_c = h_reg;
            end
            OP_D3:
            begin
                ma_c  = $signed({16'd0, t_reg});
                mb_c  = RECIP3;
                msh_c = 6'd33;
            end
            OP_G:
            begin
                ma_c = $signed({16'd0, h_reg});
                mb_c = pow2_frac(b_reg[23:21]);
            end
            OP_X:
            begin
                ma_c  = $signed({16'd0, opa_reg}) - 48'(y_reg);
                mb_c  = gain_reg;
                msh_c = 6'd24;
            end
            OP_R:
            begin
                ma_c = x_reg;
                mb_c = e_reg;
            end
            default: mul_op = 1'b0;
        endcase
    end

    // Sum partial products and floor-shift
    always_comb
    begin
        msum   = (81'(phi_reg) <<< 16) + 81'(plo_reg);
        mshift = msum >>> msh_reg;
    end

    // Scale 2^f by 2^n
    always_comb
    begin
        g   = mres_reg[31:0];
        n8  = b_reg[31:24];
        m8  = 8'd0 - n8;
        e_c = '0;
        if (!n8[7])
        begin
            if (n8[6:5] == 2'b00)
                e_c = g << n8[4:0];
        end
        else if (m8 < 8'd32)
        begin
            e_c = g >> m8[4:0];
        end
    end

    // Saturate the sum to 48 bits
    always_comb
    begin
        if (acc_reg[63:47] == {17{acc_reg[63]}})
            rate_c = acc_reg[47:0];
        else if (acc_reg[63])
            rate_c = {1'b1, 47'd0};
        else
            rate_c = {1'b0, {47{1'b1}}};
    end

    // Next raster position
    always_comb
    begin
        ni = {1'b0, i_reg} + 1'b1;
        nj = {1'b0, j_reg};
        if (ni >= nc)
        begin
            ni = '0;
            nj = nj + 1'b1;
            if (nj >= nr)
                nj = '0;
        end
    end

    rdsr_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.start && (cmd.op == OP_DIV)),
        .divisor (y_reg[30:0]),
        .quot    (quot),
        .done    (div_done)
    );

    // Control state: configuration, position, handshake flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_x_reg    <= COEF_RST;
            coef_y_reg    <= COEF_RST;
            gain_reg      <= GAIN_RST;
            opa_reg       <= OPA_RST;
            cols_reg      <= DIM_RST;
            rows_reg      <= DIM_RST;
            colc_reg      <= '0;
            rowc_reg      <= '0;
            rvalid_reg    <= 1'b0;
            mv1_reg       <= 1'b0;
            mv2_reg       <= 1'b0;
            mv3_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rvalid_reg <= cmd.rd_en;
            mv1_reg    <= cmd.start && mul_op;
            mv2_reg    <= mv1_reg;
            mv3_reg    <= mv2_reg;

            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            // advance after the store write
            if (cmd.store)
            begin
                colc_reg <= ni[IDX_W-1:0];
                rowc_reg <= nj[IDX_W-1:0];
            end

            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_COEF_X: coef_x_reg <= cfg_data;
                    CFG_COEF_Y: coef_y_reg <= cfg_data;
                    CFG_GAIN:   gain_reg   <= cfg_data;
                    CFG_OPA:    opa_reg    <= cfg_data;
                    CFG_COLS:
                    begin
                        cols_reg <= cfg_data[DIM_W-1:0];
                        colc_reg <= '0;
                        rowc_reg <= '0;
                    end
                    CFG_ROWS:
                    begin
                        rows_reg <= cfg_data[DIM_W-1:0];
                        colc_reg <= '0;
                        rowc_reg <= '0;
                    end
                    default: ;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (rvalid_reg)
            rslot_reg <= rslot_reg;
        if (cmd.rd_en)
            rslot_reg <= cmd.slot;

        // latch the word and its raster position
        if (cmd.accept)
        begin
            s_reg <= sample;
            if (({1'b0, colc_reg} >= nc) || ({1'b0, rowc_reg} >= nr))
            begin
                i_reg <= '0;
                j_reg <= '0;
            end
            else
            begin
                i_reg <= colc_reg;
                j_reg <= rowc_reg;
            end
        end

        // drop read data into its operand slot
        if (rvalid_reg)
        begin
            unique case (rslot_reg)
                SLOT_Y:     y_reg     <= rdata_reg;
                SLOT_LEFT:  left_reg  <= rdata_reg;
                SLOT_RIGHT: right_reg <= rdata_reg;
                SLOT_UP:    up_reg    <= rdata_reg;
            endcase
        end

        // operations done without the multiplier, and multiplier launch
        if (cmd.start)
        begin
            if (cmd.op == OP_LAP)
            begin
                y_reg     <= yv;
                right_reg <= rv;
                lx_reg    <= lx_c;
                ly_reg    <= ly_c;
                dom_reg   <= yv[31] || (yv == '0);
                acc_reg   <= '0;
            end
            if (cmd.op == OP_H0)
                h_reg <= ONE30 + (u_reg >> 2);
            if (mul_op)
            begin
                ma_reg  <= ma_c;
                mb_reg  <= mb_c;
                msh_reg <= msh_c;
                mop_reg <= cmd.op;
            end
        end

        // multiplier stages
        plo_reg  <= ma_reg * $signed({1'b0, mb_reg[15:0]});
        phi_reg  <= ma_reg * $signed({1'b0, mb_reg[31:16]});
        mres_reg <= mshift[63:0];

        // write back the product
        if (mv3_reg)
        begin
            unique case (mop_reg)
                OP_MX, OP_MY, OP_R: acc_reg <= acc_reg + mres_reg;
                OP_B:               b_reg   <= mres_reg[31:0];
                OP_U:               u_reg   <= mres_reg[31:0];
                OP_UH1:             t_reg   <= mres_reg[31:0];
                OP_D3:              h_reg   <= ONE30 + mres_reg[31:0];
                OP_UH2:             h_reg   <= ONE30 + mres_reg[32:1];
                OP_UH3:             h_reg   <= ONE30 + mres_reg[31:0];
                OP_G:               e_reg   <= e_c;
                OP_X:               x_reg   <= mres_reg[47:0];
                default: ;
            endcase
        end

        // exponent argument 1 - 1/y
        if (div_done)
            a_reg <= 50'sd16777216 - $signed({1'b0, quot});

        // hold the result word
        if (cmd.emit)
        begin
            col_reg     <= jc;
            row_reg     <= jr;
            rate_reg    <= rate_c;
            dom_out_reg <= dom_reg;
            last_reg    <= cmd.last;
        end
    end

    always_comb
    begin
        sts.dom      = dom_reg;
        sts.a_small  = a_reg < -50'sd1073741824;
        sts.mul_done = mv3_reg;
        sts.div_done = div_done;
        sts.out_free = !out_valid_reg || out_ready;
    end

    assign out_valid    = out_valid_reg;
    assign col          = col_reg;
    assign row          = row_reg;
    assign rate         = rate_reg;
    assign domain_error = dom_out_reg;
    assign last         = last_reg;

endmodule

`default_nettype wire

### sv/rdsr_ctrl.sv
// Controller: sequences line store reads, the arithmetic program and result words.
// Depends on rdsr_pkg; drives rdsr_dp through cmd_t and reads sts_t.
`default_nettype none

module rdsr_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    output rdsr_pkg::cmd_t       cmd,
    input  wire rdsr_pkg::sts_t  sts
);
    import rdsr_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_SETUP = 6'b000010,
        ST_READ  = 6'b000100,
        ST_MATH  = 6'b001000,
        ST_EMIT  = 6'b010000,
        ST_STORE = 6'b100000
    } state_t;

    state_t     state_reg, state_next;
    logic [2:0] pend_reg, pend_next;
    logic [2:0] rcnt_reg, rcnt_next;
    op_t        pc_reg, pc_next;
    logic       busy_reg, busy_next;

    job_t       cur_job;
    logic [2:0] rest;

    // Pick the next pending job
    always_comb
    begin
        rest = pend_reg;
        priority if (pend_reg[0])
        begin
            cur_job = JOB_A;
            rest[0] = 1'b0;
        end
        else if (pend_reg[1])
        begin
            cur_job = JOB_B;
            rest[1] = 1'b0;
        end
        else
        begin
            cur_job = JOB_C;
            rest[2] = 1'b0;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        pend_next  = pend_reg;
        rcnt_next  = rcnt_reg;
        pc_next    = pc_reg;
        busy_next  = busy_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        cmd.job    = cur_job;
        cmd.slot   = slot_t'(rcnt_reg[1:0]);
        cmd.op     = pc_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                pend_next = sts.jobs;
                rcnt_next = '0;
                state_next = (sts.jobs == '0) ? ST_STORE : ST_READ;
            end
            ST_READ:
            begin
                // issue four reads, then let the last one land
                cmd.rd_en = !rcnt_reg[2];
                rcnt_next = rcnt_reg + 1'b1;
                if (rcnt_reg[2])
                begin
                    pc_next    = OP_LAP;
                    busy_next  = 1'b0;
                    state_next = ST_MATH;
                end
            end
            ST_MATH:
            begin
                if (!busy_reg)
                begin
                    if (((pc_reg == OP_DIV) && sts.dom) ||
                        ((pc_reg == OP_B) && sts.a_small))
                    begin
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        cmd.start = 1'b1;
                        if ((pc_reg == OP_LAP) || (pc_reg == OP_H0))
                            pc_next = op_t'(pc_reg + 4'd1);
                        else
                            busy_next = 1'b1;
                    end
                end
                else if (sts.mul_done || sts.div_done)
                begin
                    busy_next = 1'b0;
                    if (pc_reg == OP_R)
                        state_next = ST_EMIT;
                    else
                        pc_next = op_t'(pc_reg + 4'd1);
                end
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.last   = (rest == '0);
                    pend_next  = rest;
                    rcnt_next  = '0;
                    state_next = (rest == '0) ? ST_STORE : ST_READ;
                end
            end
            ST_STORE:
            begin
                cmd.store  = 1'b1;
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pend_reg  <= '0;
            rcnt_reg  <= '0;
            pc_reg    <= OP_LAP;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            rcnt_reg  <= rcnt_next;
            pc_reg    <= pc_next;
            busy_reg  <= busy_next;
        end
    end

endmodule

`default_nettype wire
